// ----- rtl/lrucf_pkg.sv -----
package lrucf_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned LIMIT_W  = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_GET         = 3'd0,
    OP_PUT         = 3'd1,
    OP_INVALIDATE  = 3'd2,
    OP_CLEAR       = 3'd3,
    OP_START_FETCH = 3'd4,
    OP_END_FETCH   = 3'd5
  } op_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [DATA_W-1:0]   key;
    logic [DATA_W-1:0]   entry_value;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              fetch_granted;
    logic              fetch_table_full;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic lookup;
    logic commit;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/lrucf_ctrl.sv -----
module lrucf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lrucf_pkg::stat_t  stat_i,
  output lrucf_pkg::cmd_t   cmd_o
);
  import lrucf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_COMMIT = 4'b0100,
    ST_RESP   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign cmd_o.accept   = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.lookup   = (state_q == ST_LOOKUP);
  assign cmd_o.commit   = (state_q == ST_COMMIT);
  assign cmd_o.respond  = (state_q == ST_RESP) && stat_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_RESP;
      ST_RESP: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/lrucf_dp.sv -----
module lrucf_dp #(
  parameter int unsigned CACHE_DEPTH = 16,
  parameter int unsigned KEY_WIDTH   = 64,
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned FETCH_SLOTS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lrucf_pkg::cmd_t                    cmd_i,
  output lrucf_pkg::stat_t                   stat_o,
  input  lrucf_pkg::req_t                    in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output lrucf_pkg::rsp_t                    out_data_o,
  input  logic                               cfg_we_i,
  input  logic [lrucf_pkg::LIMIT_W-1:0]      cfg_data_i
);
  import lrucf_pkg::*;

  localparam int unsigned RW = $clog2(CACHE_DEPTH);
  localparam int unsigned CW = $clog2(CACHE_DEPTH + 1);
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  // latched request
  logic [OPCODE_W-1:0]    op_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;

  logic [LIMIT_W-1:0]     limit_q;
  logic [LW-1:0]          lim_eff;

  // cache state
  logic [KEY_WIDTH-1:0]   ent_key_q [CACHE_DEPTH];
  logic [CACHE_DEPTH-1:0] ent_valid_q, ent_valid_d;
  logic [RW-1:0]          rank_q [CACHE_DEPTH];
  logic [RW-1:0]          rank_d [CACHE_DEPTH];
  logic [CW-1:0]          count_q, count_d;
  logic [VALUE_WIDTH-1:0] val_mem [CACHE_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_q;

  // fetch table
  logic [KEY_WIDTH-1:0]   fkey_q [FETCH_SLOTS];
  logic [FETCH_SLOTS-1:0] fvalid_q, fvalid_d;

  // lookup results
  logic [CACHE_DEPTH-1:0] hit_vec, lru_vec, free_vec, alloc_vec;
  logic [RW-1:0]          hit_rank, hit_idx, alloc_idx;
  logic                   evict_c;
  logic [FETCH_SLOTS-1:0] fhit_vec, ffree_vec, ffirst_vec;

  logic [CACHE_DEPTH-1:0] hit_oh_q, lru_oh_q, alloc_oh_q;
  logic                   hit_any_q, evict_q;
  logic [RW-1:0]          hit_rank_q, hit_idx_q, alloc_idx_q;
  logic [FETCH_SLOTS-1:0] fhit_oh_q, ffree_oh_q;

  // commit controls
  logic [CACHE_DEPTH-1:0] ent_write;
  logic [FETCH_SLOTS-1:0] fwrite;
  logic                   mem_we;
  logic [RW-1:0]          mem_waddr;
  logic                   hit_d, granted_d, full_d;
  logic                   rsp_hit_q, rsp_granted_q, rsp_full_q;

  logic                   out_valid_q;
  rsp_t                   out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= in_data_i.opcode;
      key_q <= in_data_i.key[KEY_WIDTH-1:0];
      val_q <= in_data_i.entry_value[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // limit clamped to 1..CACHE_DEPTH
  always_comb begin
    if (limit_q == '0) begin
      lim_eff = LW'(1);
    end else if (LW'(limit_q) > LW'(CACHE_DEPTH)) begin
      lim_eff = LW'(CACHE_DEPTH);
    end else begin
      lim_eff = LW'(limit_q);
    end
  end

  always_comb begin
    hit_rank = '0;
    hit_idx  = '0;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      hit_vec[i] = ent_valid_q[i] && (ent_key_q[i] == key_q);
      lru_vec[i] = ent_valid_q[i] && (rank_q[i] == RW'(count_q - CW'(1)));
      if (hit_vec[i]) begin
        hit_rank = hit_rank | rank_q[i];
        hit_idx  = hit_idx | RW'(i);
      end
    end
    evict_c   = !(|hit_vec) && (LW'(count_q) >= lim_eff);
    free_vec  = ~ent_valid_q | (evict_c ? lru_vec : '0);
    alloc_vec = free_vec & (~free_vec + CACHE_DEPTH'(1));
    alloc_idx = '0;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (alloc_vec[i]) alloc_idx = alloc_idx | RW'(i);
    end
    for (int j = 0; j < FETCH_SLOTS; j++) begin
      fhit_vec[j] = fvalid_q[j] && (fkey_q[j] == key_q);
    end
    ffree_vec  = ~fvalid_q;
    ffirst_vec = ffree_vec & (~ffree_vec + FETCH_SLOTS'(1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_oh_q    <= hit_vec;
      hit_any_q   <= |hit_vec;
      hit_rank_q  <= hit_rank;
      hit_idx_q   <= hit_idx;
      lru_oh_q    <= lru_vec;
      evict_q     <= evict_c;
      alloc_oh_q  <= alloc_vec;
      alloc_idx_q <= alloc_idx;
      fhit_oh_q   <= fhit_vec;
      ffree_oh_q  <= ffirst_vec;
    end
  end

  always_comb begin
    ent_valid_d = ent_valid_q;
    rank_d      = rank_q;
    count_d     = count_q;
    fvalid_d    = fvalid_q;
    ent_write   = '0;
    fwrite      = '0;
    mem_we      = 1'b0;
    mem_waddr   = hit_any_q ? hit_idx_q : alloc_idx_q;
    hit_d       = 1'b0;
    granted_d   = 1'b0;
    full_d      = 1'b0;
    case (op_q)
      OP_GET, OP_PUT: begin
        mem_we = (op_q == OP_PUT);
        if (hit_any_q) begin
          hit_d = (op_q == OP_GET);
          // promote
          for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (hit_oh_q[i]) begin
              rank_d[i] = '0;
            end else if (ent_valid_q[i] && (rank_q[i] < hit_rank_q)) begin
              rank_d[i] = rank_q[i] + RW'(1);
            end
          end
        end else if (op_q == OP_PUT) begin
          ent_write = alloc_oh_q;
          for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (alloc_oh_q[i]) begin
              ent_valid_d[i] = 1'b1;
              rank_d[i]      = '0;
            end else if (evict_q && lru_oh_q[i]) begin
              ent_valid_d[i] = 1'b0;
            end else if (ent_valid_q[i]) begin
              rank_d[i] = rank_q[i] + RW'(1);
            end
          end
          if (!evict_q) count_d = count_q + CW'(1);
        end
      end
      OP_INVALIDATE: begin
        if (hit_any_q) begin
          for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (hit_oh_q[i]) begin
              ent_valid_d[i] = 1'b0;
            end else if (ent_valid_q[i] && (rank_q[i] > hit_rank_q)) begin
              rank_d[i] = rank_q[i] - RW'(1);
            end
          end
          count_d = count_q - CW'(1);
        end
      end
      OP_CLEAR: begin
        ent_valid_d = '0;
        fvalid_d    = '0;
        count_d     = '0;
      end
      OP_START_FETCH: begin
        if (!(|fhit_oh_q)) begin
          if (|ffree_oh_q) begin
            fvalid_d  = fvalid_q | ffree_oh_q;
            fwrite    = ffree_oh_q;
            granted_d = 1'b1;
          end else begin
            full_d = 1'b1;
          end
        end
      end
      OP_END_FETCH: begin
        fvalid_d = fvalid_q & ~fhit_oh_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      count_q     <= '0;
      fvalid_q    <= '0;
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      ent_valid_q <= ent_valid_d;
      count_q     <= count_d;
      fvalid_q    <= fvalid_d;
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        if (ent_write[i]) ent_key_q[i] <= key_q;
      end
      for (int j = 0; j < FETCH_SLOTS; j++) begin
        if (fwrite[j]) fkey_q[j] <= key_q;
      end
    end
  end

  // value store, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (mem_we) val_mem[mem_waddr] <= val_q;
      rd_q <= val_mem[hit_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_hit_q     <= hit_d;
      rsp_granted_q <= granted_d;
      rsp_full_q    <= full_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.respond) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      out_q.hit              <= rsp_hit_q;
      out_q.read_value       <= rsp_hit_q ? DATA_W'(rd_q) : '0;
      out_q.fetch_granted    <= rsp_granted_q;
      out_q.fetch_table_full <= rsp_full_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ----- rtl/lru_cache_with_fetch_tracking_top.sv -----
// result path: after the input transfer come the lookup, commit and response
//   steps of the controller sequence, then the output register and any stall;
//   items pass one at a time, and a new item is taken while the last result waits
// reset: asynchronous active low, empties cache and fetch table, limit becomes 16
module lru_cache_with_fetch_tracking_top #(
  parameter int unsigned CACHE_DEPTH = 16,
  parameter int unsigned KEY_WIDTH   = 64,
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned FETCH_SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lrucf_pkg::req_t               in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lrucf_pkg::rsp_t               out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lrucf_pkg::LIMIT_W-1:0] cfg_data_i
);
  import lrucf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lrucf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lrucf_dp #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .FETCH_SLOTS (FETCH_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

`ifndef SYNTH
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.lookup, cmd.commit, cmd.respond}))
    else $error("controller issued more than one command");

  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> cmd.lookup)
    else $error("transfer not followed by lookup");

  a_lookup_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.lookup |=> cmd.commit && !in_ready_o)
    else $error("lookup not followed by commit");

  a_rsp_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_data_o.hit, out_data_o.fetch_granted,
                              out_data_o.fetch_table_full}))
    else $error("conflicting result flags");
`endif

endmodule

// ----- verif/cache_result_checker.sv -----
`timescale 1ns / 1ps

module cache_result_checker
  import lrucf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  req_t                 in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  rsp_t                 out_data_i,
  input  logic                 cfg_we_i,
  input  logic [LIMIT_W-1:0]   cfg_data_i,
  output int                   fail_count_o,
  output int                   outstanding_o,
  output int                   compared_o
);

  localparam int CACHE_DEPTH = 16;
  localparam int FETCH_SLOTS = 8;

  logic [DATA_W-1:0]  cache_key [CACHE_DEPTH];
  logic [DATA_W-1:0]  cache_val [CACHE_DEPTH];
  bit                 cache_used [CACHE_DEPTH];
  int unsigned        age_rank [CACHE_DEPTH];
  logic [DATA_W-1:0]  fetch_key [FETCH_SLOTS];
  bit                 fetch_busy [FETCH_SLOTS];
  logic [LIMIT_W-1:0] limit_q;
  rsp_t               expected_rsp_q [$];

  function automatic int find_entry_slot(logic [DATA_W-1:0] k);
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (cache_used[i] && cache_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void make_newest(int s);
    int unsigned r;
    r = age_rank[s];
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (cache_used[i] && age_rank[i] < r) age_rank[i]++;
    end
    age_rank[s] = 0;
  endfunction

  function automatic void remove_entry(int s);
    int unsigned r;
    r = age_rank[s];
    cache_used[s] = 0;
    age_rank[s] = 0;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (cache_used[i] && age_rank[i] > r) age_rank[i]--;
    end
  endfunction

  function automatic void store_entry(logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
    int s;
    int unsigned lim;
    int unsigned held;
    int oldest;
    int unsigned oldest_rank;
    s = find_entry_slot(k);
    if (s >= 0) begin
      cache_val[s] = v;
      make_newest(s);
      return;
    end
    lim = limit_q;
    if (lim < 1) lim = 1;
    if (lim > CACHE_DEPTH) lim = CACHE_DEPTH;
    held = 0;
    for (int i = 0; i < CACHE_DEPTH; i++) held += cache_used[i];
    if (held >= lim) begin
      oldest = -1;
      oldest_rank = 0;
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        if (cache_used[i] && (oldest < 0 || age_rank[i] > oldest_rank)) begin
          oldest = i;
          oldest_rank = age_rank[i];
        end
      end
      if (oldest >= 0) remove_entry(oldest);
    end
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (!cache_used[i]) begin
        cache_key[i] = k;
        cache_val[i] = v;
        cache_used[i] = 1;
        age_rank[i] = CACHE_DEPTH;
        make_newest(i);
        return;
      end
    end
  endfunction

  function automatic rsp_t predict_cache_op(req_t r);
    rsp_t res;
    int s;
    res = '0;
    case (r.opcode)
      OP_GET: begin
        s = find_entry_slot(r.key);
        if (s >= 0) begin
          res.hit = 1'b1;
          res.read_value = cache_val[s];
          make_newest(s);
        end
      end
      OP_PUT: store_entry(r.key, r.entry_value);
      OP_INVALIDATE: begin
        s = find_entry_slot(r.key);
        if (s >= 0) remove_entry(s);
      end
      OP_CLEAR: begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
          cache_used[i] = 0;
          age_rank[i] = 0;
        end
        for (int i = 0; i < FETCH_SLOTS; i++) fetch_busy[i] = 0;
      end
      OP_START_FETCH: begin
        s = -1;
        for (int i = 0; i < FETCH_SLOTS; i++) begin
          if (fetch_busy[i] && fetch_key[i] == r.key) s = i;
        end
        if (s < 0) begin
          for (int i = 0; i < FETCH_SLOTS; i++) begin
            if (!fetch_busy[i]) begin
              s = i;
              break;
            end
          end
          if (s >= 0) begin
            fetch_key[s] = r.key;
            fetch_busy[s] = 1;
            res.fetch_granted = 1'b1;
          end else begin
            res.fetch_table_full = 1'b1;
          end
        end
      end
      OP_END_FETCH: begin
        for (int i = 0; i < FETCH_SLOTS; i++) begin
          if (fetch_busy[i] && fetch_key[i] == r.key) fetch_busy[i] = 0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    int pushed;
    int popped;
    if (!rst_ni) begin
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        cache_used[i] = 0;
        age_rank[i] = 0;
      end
      for (int i = 0; i < FETCH_SLOTS; i++) fetch_busy[i] = 0;
      limit_q = LIMIT_RST;
      expected_rsp_q.delete();
      outstanding_o <= 0;
      fail_count_o = 0;
      compared_o = 0;
    end else begin
      pushed = 0;
      popped = 0;
      if (cfg_we_i) limit_q = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count_o++;
        end else begin
          want = expected_rsp_q.pop_front();
          popped = 1;
          compared_o++;
          if (out_data_i.hit !== want.hit) begin
            $error("hit: expected %0h, got %0h", want.hit, out_data_i.hit);
            fail_count_o++;
          end
          if (out_data_i.read_value !== want.read_value) begin
            $error("read_value: expected %0h, got %0h", want.read_value,
                   out_data_i.read_value);
            fail_count_o++;
          end
          if (out_data_i.fetch_granted !== want.fetch_granted) begin
            $error("fetch_granted: expected %0h, got %0h", want.fetch_granted,
                   out_data_i.fetch_granted);
            fail_count_o++;
          end
          if (out_data_i.fetch_table_full !== want.fetch_table_full) begin
            $error("fetch_table_full: expected %0h, got %0h", want.fetch_table_full,
                   out_data_i.fetch_table_full);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_rsp_q.push_back(predict_cache_op(in_data_i));
        pushed = 1;
      end
      outstanding_o <= outstanding_o + pushed - popped;
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import lrucf_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
  localparam logic [DATA_W-1:0]   ALL_ONES    = '1;
  localparam int                  POOL_SIZE   = 24;
  localparam int                  PHASE_ITEMS = 62;
  localparam int                  HOLD_CYCLES = 200;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  req_t               in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  rsp_t               out_data_o;
  logic               cfg_we_i;
  logic [LIMIT_W-1:0] cfg_data_i;

  int fail_count;
  int outstanding;
  int compared;
  int ops_sent;
  bit idle_en;
  bit hold_off_req;

  logic [DATA_W-1:0]  key_pool [POOL_SIZE];
  logic [LIMIT_W-1:0] limit_plan [8] = '{5'd4, 5'd0, 5'd31, 5'd1, 5'd16, 5'd3, 5'd17, 5'd8};

  lru_cache_with_fetch_tracking_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  cache_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .compared_o    (compared)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #500_000;
    $display("FAIL lru_cache_with_fetch_tracking_top");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int gap;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 0;
      end
      gap = idle_en ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] k,
                         input logic [DATA_W-1:0] v);
    int gap;
    req_t r;
    gap = idle_en ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    r.opcode = op;
    r.key = k;
    r.entry_value = v;
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    ops_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] lim);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [DATA_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return rand_word();
  endfunction

  task automatic send_random_op();
    int roll;
    logic [OPCODE_W-1:0] op;
    roll = $urandom_range(0, 99);
    if (roll < 34) op = OP_GET;
    else if (roll < 68) op = OP_PUT;
    else if (roll < 78) op = OP_INVALIDATE;
    else if (roll < 87) op = OP_START_FETCH;
    else if (roll < 96) op = OP_END_FETCH;
    else if (roll < 98) op = OP_CLEAR;
    else if (roll == 98) op = OP_SPARE_LO;
    else op = OP_SPARE_HI;
    send_op(op, pick_key(), rand_word());
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_data_i <= '0;
    idle_en = 1;
    hold_off_req = 0;
    ops_sent = 0;
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = rand_word();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pass at the reset limit
    send_op(OP_PUT, '0, ALL_ONES);
    send_op(OP_PUT, ALL_ONES, '0);
    send_op(OP_GET, '0, '0);
    send_op(OP_GET, 64'd5, ALL_ONES);
    send_op(OP_PUT, '0, 64'h0123_4567_89ab_cdef);
    send_op(OP_INVALIDATE, ALL_ONES, '0);
    send_op(OP_INVALIDATE, 64'd7, '0);
    send_op(OP_GET, ALL_ONES, '0);
    for (int i = 1; i <= 8; i++) send_op(OP_START_FETCH, DATA_W'(i), '0);
    send_op(OP_START_FETCH, 64'd1, '0);
    send_op(OP_START_FETCH, 64'd9, '0);
    send_op(OP_END_FETCH, 64'd3, '0);
    send_op(OP_END_FETCH, 64'd99, '0);
    send_op(OP_START_FETCH, 64'd9, '0);
    send_op(OP_SPARE_LO, '0, ALL_ONES);
    send_op(OP_SPARE_HI, ALL_ONES, ALL_ONES);
    send_op(OP_CLEAR, '0, '0);
    send_op(OP_GET, '0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      set_limit(limit_plan[ph]);
      idle_en = (ph != 1 && ph != 4);
      if (ph == 4) hold_off_req = 1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_op();
    end
    drain();

    $display("%0d cache operations over %0d limit settings, %0d results compared",
             ops_sent, 9, compared);
    $display("limits covered include 0, 1, 31 and lowering below the held count");
    if (fail_count == 0) begin
      $display("PASS lru_cache_with_fetch_tracking_top");
    end else begin
      $display("FAIL lru_cache_with_fetch_tracking_top");
    end
    $finish;
  end

endmodule
